// ----- rtl/core/json_string_escaper_utf8_filter_assert.svh -----
// Assertion macros used by the port-level checker file of the JSON string escaper.
`ifndef JSON_STRING_ESCAPER_UTF8_FILTER_ASSERT_SVH
`define JSON_STRING_ESCAPER_UTF8_FILTER_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define JSEF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jsef: same-cycle check failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define JSEF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jsef: next-cycle check failed");

`endif

// ----- rtl/core/jsef_pkg.sv -----
// Package with beat types, run type and character constants of the JSON escaper.
package jsef_pkg;

  // Longest escape run that one input beat can cause (\u00xx).
  localparam int MaxRunBytes = 6;
  localparam int RunCntW     = $clog2(MaxRunBytes + 1);
  localparam int PendDepth   = 3;
  localparam int RunQueueDepth = 2;

  // Characters used in the escaped stream.
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChReturn    = 8'h0D;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerU    = 8'h75;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] TermByte    = 8'h00;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_in_run;
    logic       string_done;
  } out_beat_t;

  // All result bytes of one input beat, first byte at index 0.
  typedef struct packed {
    logic [MaxRunBytes-1:0][7:0] bytes;
    logic [RunCntW-1:0]          cnt;
    logic                        done;
  } run_t;

  // Fill status of the run queue seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/core/jsef_front.sv -----
// Front end: accepts input beats, tracks UTF-8 sequences and builds escape runs.
module jsef_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  jsef_pkg::in_beat_t in_beat,
  input  jsef_pkg::q_stat_t  q_stat,
  output logic              push,
  output jsef_pkg::run_t     push_run
);
  import jsef_pkg::*;

  logic [7:0] pend_r   [PendDepth];
  logic [7:0] pend_nxt [PendDepth];
  logic [1:0] pcnt_r, pcnt_nxt;
  logic [2:0] slen_r, slen_nxt;
  logic       accept;
  logic       held;
  logic       is_cont;
  logic [7:0] b;
  logic [2:0] lead;
  run_t       run;

  // Sequence length announced by a byte: 1 for ASCII, 0 for no valid lead.
  function automatic logic [2:0] lead_len(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    priority if (!v[7])               r = 3'd1;
    else if (v[7:5] == 3'b110)        r = 3'd2;
    else if (v[7:4] == 4'b1110)       r = 3'd3;
    else if (v[7:3] == 5'b11110)      r = 3'd4;
    else                              r = 3'd0;
    return r;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] r;
    r = (n < 4'd10) ? (ChZero + {4'd0, n}) : (8'h57 + {4'd0, n});
    return r;
  endfunction

  // Result run of a byte handled with nothing held; leads give an empty run.
  function automatic run_t fresh_run(input logic [7:0] v);
    run_t r;
    r = '0;
    priority if (v == ChQuote || v == ChBackslash) begin
      r.bytes[0] = ChBackslash;
      r.bytes[1] = v;
      r.cnt      = RunCntW'(2);
    end else if (v == ChNewline || v == ChReturn || v == ChTab) begin
      r.bytes[0] = ChBackslash;
      r.bytes[1] = (v == ChNewline) ? ChLowerN : ((v == ChReturn) ? ChLowerR : ChLowerT);
      r.cnt      = RunCntW'(2);
    end else if (v < ChSpace) begin
      r.bytes[0] = ChBackslash;
      r.bytes[1] = ChLowerU;
      r.bytes[2] = ChZero;
      r.bytes[3] = ChZero;
      r.bytes[4] = hex_digit(v[7:4]);
      r.bytes[5] = hex_digit(v[3:0]);
      r.cnt      = RunCntW'(6);
    end else if (!v[7]) begin
      r.bytes[0] = v;
      r.cnt      = RunCntW'(1);
    end else begin
      // Leads, stray continuations and invalid bytes give no result here.
      r = '0;
    end
    return r;
  endfunction

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign b        = in_beat.in_byte;
  assign held     = (slen_r != 3'd0) && (pcnt_r != 2'd0);
  assign is_cont  = (b[7:6] == 2'b10);
  assign lead     = lead_len(b);

  // Classify the beat and work out the held state that follows it.
  always_comb begin
    pend_nxt = pend_r;
    pcnt_nxt = pcnt_r;
    slen_nxt = slen_r;
    run      = '0;
    priority if (in_beat.string_end) begin
      pcnt_nxt     = 2'd0;
      slen_nxt     = 3'd0;
      run.bytes[0] = TermByte;
      run.cnt      = RunCntW'(1);
      run.done     = 1'b1;
    end else if (held && is_cont) begin
      priority if (({1'b0, pcnt_r} + 3'd1) >= slen_r) begin
        // Sequence complete: held bytes first, then this continuation.
        run.bytes[0] = pend_r[0];
        run.bytes[1] = (pcnt_r >= 2'd2) ? pend_r[1] : b;
        run.bytes[2] = (pcnt_r == 2'd3) ? pend_r[2] : b;
        run.bytes[3] = b;
        run.cnt      = RunCntW'({1'b0, pcnt_r} + 3'd1);
        pcnt_nxt     = 2'd0;
        slen_nxt     = 3'd0;
      end else if (pcnt_r < 2'd3) begin
        pend_nxt[pcnt_r] = b;
        pcnt_nxt         = pcnt_r + 2'd1;
      end else begin
        pcnt_nxt = 2'd0;
        slen_nxt = 3'd0;
      end
    end else begin
      // Nothing held, or a broken sequence: start over with this byte.
      pcnt_nxt = 2'd0;
      slen_nxt = 3'd0;
      run      = fresh_run(b);
      if (lead > 3'd1) begin
        pend_nxt[0] = b;
        pcnt_nxt    = 2'd1;
        slen_nxt    = lead;
      end
    end
  end

  assign push     = accept && (run.cnt != '0);
  assign push_run = run;

  // Sequence tracking state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= 2'd0;
      slen_r <= 3'd0;
    end else if (accept) begin
      pcnt_r <= pcnt_nxt;
      slen_r <= slen_nxt;
    end
  end

  // Held bytes carry no reset; only entries below the count are read.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_r <= pend_nxt;
    end
  end

endmodule

// ----- rtl/core/jsef_run_fifo.sv -----
// Short queue of escape runs between the front end and the serializer.
module jsef_run_fifo #(
  parameter int Depth = jsef_pkg::RunQueueDepth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  jsef_pkg::run_t     push_run,
  input  logic              pop,
  output jsef_pkg::run_t     head_run,
  output jsef_pkg::q_stat_t  q_stat
);
  import jsef_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  run_t            mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == CntW'(Depth));
  assign q_stat.empty = (cnt_r == '0);
  assign head_run     = mem_r[rd_ptr_r];

  // Pointer wrap works for any depth of two or more, not only powers of two.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CntW'(1);
      2'b01:   cnt_nxt = cnt_r - CntW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_run;
    end
  end

endmodule

// ----- rtl/core/jsef_back.sv -----
// Back end: serializes queued escape runs into output beats, one byte per cycle unless out_stall holds it.
module jsef_back (
  input  logic              clk,
  input  logic              rst_n,
  input  jsef_pkg::q_stat_t  q_stat,
  input  jsef_pkg::run_t     head_run,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output jsef_pkg::out_beat_t out_beat
);
  import jsef_pkg::*;

  run_t               run_r, run_nxt;
  logic [RunCntW-1:0] idx_r, idx_nxt;
  logic               busy_r, busy_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_beat_r, out_beat_nxt;
  logic               advance;
  logic               src_valid;
  run_t               src;
  logic [RunCntW-1:0] src_idx;
  logic               src_last;

  // A run in progress has priority; otherwise the queue head starts at byte 0.
  assign advance   = !out_valid_r || !out_stall;
  assign src_valid = busy_r || !q_stat.empty;
  assign src       = busy_r ? run_r : head_run;
  assign src_idx   = busy_r ? idx_r : '0;
  assign src_last  = ((src_idx + RunCntW'(1)) == src.cnt);

  always_comb begin
    run_nxt       = run_r;
    idx_nxt       = idx_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    pop           = 1'b0;
    if (advance) begin
      out_valid_nxt = src_valid;
      if (src_valid) begin
        out_beat_nxt.out_byte    = src.bytes[src_idx];
        out_beat_nxt.last_in_run = src_last;
        out_beat_nxt.string_done = src.done;
        if (busy_r) begin
          if (src_last) begin
            busy_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + RunCntW'(1);
          end
        end else begin
          pop = 1'b1;
          if (!src_last) begin
            run_nxt  = head_run;
            idx_nxt  = RunCntW'(1);
            busy_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    run_r      <= run_nxt;
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

// ----- rtl/core/json_string_escaper_utf8_filter.sv -----
// Top level of the JSON string escaper with UTF-8 filtering.
// Each input beat carries one source byte (or an end mark) and turns into a run of
// zero to six output bytes. The serializer emits one output byte per cycle unless
// out_stall holds it, so output bandwidth sets the rate: each beat is paid for by
// the bytes it produces; a held UTF-8 lead or dropped byte produces none. Input is
// accepted one beat per cycle as long as the run queue (RUN_QUEUE_DEPTH runs, at
// least 2) has room; plain ASCII text flows at one byte per cycle end to end while
// out_stall is low. Runs pass the run queue and the serializer's output register.
// A UTF-8 sequence is released as a whole when its final continuation arrives.
module json_string_escaper_utf8_filter #(
  parameter int RUN_QUEUE_DEPTH = jsef_pkg::RunQueueDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  jsef_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output jsef_pkg::out_beat_t out_beat
);
  import jsef_pkg::*;

  logic    push;
  logic    pop;
  run_t    push_run;
  run_t    head_run;
  q_stat_t q_stat;

  jsef_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .q_stat   (q_stat),
    .push     (push),
    .push_run (push_run)
  );

  jsef_run_fifo #(
    .Depth (RUN_QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .head_run (head_run),
    .q_stat   (q_stat)
  );

  jsef_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_run  (head_run),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule

// ----- rtl/core/jsef_checker.sv -----
// Port-level checks of the JSON escaper and the bind that attaches them.
`include "json_string_escaper_utf8_filter_assert.svh"

module jsef_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input jsef_pkg::out_beat_t out_beat
);
  import jsef_pkg::*;

  // A stalled output beat stays offered.
  `JSEF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // The terminator is a zero byte and closes its run.
  `JSEF_ASSERT_NOW(a_done_zero, out_valid && out_beat.string_done, out_beat.out_byte == TermByte)
  `JSEF_ASSERT_NOW(a_done_last, out_valid && out_beat.string_done, out_beat.last_in_run)

  // Control bytes are always escaped, so a raw zero byte is only ever the terminator.
  `JSEF_ASSERT_NOW(a_zero_is_term, out_valid && (out_beat.out_byte == TermByte),
                   out_beat.string_done)

endmodule

bind json_string_escaper_utf8_filter jsef_checker u_jsef_checker (.*);

// ----- tb/sv/jsef_escape_checker.sv -----
// Checker that predicts the escaped byte stream of the JSON escaper and compares it beat by beat.
`timescale 1ns / 100ps
module jsef_escape_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  jsef_pkg::in_beat_t  in_beat,
  input  logic                out_valid,
  input  logic                out_stall,
  input  jsef_pkg::out_beat_t out_beat,
  output int                  error_count,
  output int                  bytes_owed
);
  import jsef_pkg::*;

  localparam logic [7:0] ChLowerA = 8'h61;

  // Escaped bytes the block still owes, oldest first.
  out_beat_t owed_q[$];
  // Bytes caused by the input beat being predicted.
  out_beat_t run_q[$];

  // Predicted state of the UTF-8 collector.
  logic [7:0] held_bytes [PendDepth];
  int         held_count = 0;
  int         seq_len = 0;

  initial begin
    error_count = 0;
    bytes_owed = 0;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return ChZero + {4'h0, nib};
    return ChLowerA + {4'h0, nib} - 8'd10;
  endfunction

  function automatic void add_byte(input logic [7:0] b, input logic done);
    out_beat_t r;
    r.out_byte = b;
    r.last_in_run = 1'b0;
    r.string_done = done;
    run_q.push_back(r);
  endfunction

  // Escapes a byte that arrives with nothing held; a UTF-8 lead starts a new sequence.
  task automatic escape_fresh(input logic [7:0] b);
    case (b)
      ChQuote, ChBackslash: begin
        add_byte(ChBackslash, 1'b0);
        add_byte(b, 1'b0);
      end
      ChNewline: begin
        add_byte(ChBackslash, 1'b0);
        add_byte(ChLowerN, 1'b0);
      end
      ChReturn: begin
        add_byte(ChBackslash, 1'b0);
        add_byte(ChLowerR, 1'b0);
      end
      ChTab: begin
        add_byte(ChBackslash, 1'b0);
        add_byte(ChLowerT, 1'b0);
      end
      default: begin
        if (b < ChSpace) begin
          add_byte(ChBackslash, 1'b0);
          add_byte(ChLowerU, 1'b0);
          add_byte(ChZero, 1'b0);
          add_byte(ChZero, 1'b0);
          add_byte(hex_char(b[7:4]), 1'b0);
          add_byte(hex_char(b[3:0]), 1'b0);
        end else if (!b[7]) begin
          add_byte(b, 1'b0);
        end else begin
          // Leads F8 and above and stray continuations leave nothing held.
          if (b[7:5] == 3'b110) seq_len = 2;
          else if (b[7:4] == 4'b1110) seq_len = 3;
          else if (b[7:3] == 5'b11110) seq_len = 4;
          if (seq_len != 0) begin
            held_bytes[0] = b;
            held_count = 1;
          end
        end
      end
    endcase
  endtask

  // Works out the bytes caused by one accepted input beat and queues them.
  task automatic predict_beat(input in_beat_t beat);
    logic [7:0] b;
    b = beat.in_byte;
    run_q.delete();
    if (beat.string_end) begin
      held_count = 0;
      seq_len = 0;
      add_byte(TermByte, 1'b1);
    end else if (seq_len != 0 && held_count != 0 && b[7:6] == 2'b10) begin
      if (held_count + 1 >= seq_len) begin
        // The final continuation releases the whole sequence.
        for (int i = 0; i < held_count; i++) add_byte(held_bytes[i], 1'b0);
        add_byte(b, 1'b0);
        held_count = 0;
        seq_len = 0;
      end else if (held_count < PendDepth) begin
        held_bytes[held_count] = b;
        held_count++;
      end else begin
        held_count = 0;
        seq_len = 0;
      end
    end else begin
      // A broken sequence is dropped and the new byte is handled afresh.
      held_count = 0;
      seq_len = 0;
      escape_fresh(b);
    end
    if (run_q.size() > 0) run_q[$].last_in_run = 1'b1;
    foreach (run_q[i]) owed_q.push_back(run_q[i]);
  endtask

  // Sample both channels at the clock edge, input side first.
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      held_count = 0;
      seq_len = 0;
      owed_q.delete();
    end else begin
      if (in_valid && !in_stall) predict_beat(in_beat);
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          $error("out beat with nothing expected: out_byte %h", out_beat.out_byte);
          error_count++;
        end else begin
          want = owed_q.pop_front();
          if (out_beat.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_beat.out_byte);
            error_count++;
          end
          if (out_beat.last_in_run !== want.last_in_run) begin
            $error("last_in_run: expected %b, got %b", want.last_in_run, out_beat.last_in_run);
            error_count++;
          end
          if (out_beat.string_done !== want.string_done) begin
            $error("string_done: expected %b, got %b", want.string_done, out_beat.string_done);
            error_count++;
          end
        end
      end
    end
    bytes_owed <= owed_q.size();
  end

endmodule

// ----- tb/sv/tb_json_string_escaper_utf8_filter.sv -----
// Testbench top of the JSON string escaper: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 100ps
module tb_json_string_escaper_utf8_filter;
  import jsef_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int RandomBeats = 186;

  // Lead and continuation prefixes of UTF-8.
  localparam logic [7:0] ContBase    = 8'h80;
  localparam logic [7:0] LeadTwo     = 8'hC0;
  localparam logic [7:0] LeadThree   = 8'hE0;
  localparam logic [7:0] LeadFour    = 8'hF0;
  localparam logic [7:0] InvalidLead = 8'hF8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  int error_count;
  int bytes_owed;
  int cycle_count = 0;
  int beats_sent = 0;
  int rx_wait = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  // Directed text: escapes, extremes, a stray continuation and UTF-8 sequences.
  logic [7:0] directed_q[$] = '{
    8'h00, 8'hFF, ChQuote, ChBackslash, ChNewline, ChReturn, ChTab, 8'h1F, 8'h7F, 8'h80,
    8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
    8'hE2, 8'h41, 8'hF7, 8'hBF
  };

  json_string_escaper_utf8_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  jsef_escape_checker u_escape_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_beat     (in_beat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_beat    (out_beat),
    .error_count (error_count),
    .bytes_owed  (bytes_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("** json_string_escaper_utf8_filter: FAILED **");
      $finish;
    end
  end

  // Output side: after each accepted beat, stall for a random number of cycles.
  always @(posedge clk) begin
    if (out_valid && !out_stall) rx_wait = rx_quiet ? 0 : $urandom_range(0, 9);
    else if (rx_wait > 0) rx_wait--;
    out_stall <= (rx_wait != 0);
  end

  // Idles for a random gap, then holds the beat until the block takes it.
  task automatic send_beat(input logic [7:0] b, input logic is_end);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_beat <= '{in_byte: b, string_end: is_end};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // Sends a UTF-8 sequence of the given length, leaving off the last cut continuations.
  task automatic send_utf8(input int len, input int cut);
    logic [7:0] lead;
    case (len)
      2: lead = LeadTwo + 8'($urandom_range(0, 31));
      3: lead = LeadThree + 8'($urandom_range(0, 15));
      default: lead = LeadFour + 8'($urandom_range(0, 7));
    endcase
    send_beat(lead, 1'b0);
    for (int i = 1; i < len - cut; i++) send_beat(ContBase + 8'($urandom_range(0, 63)), 1'b0);
  endtask

  initial begin
    int kind;
    int len;
    int round;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part ends with an end mark while a sequence is held.
    foreach (directed_q[i]) send_beat(directed_q[i], 1'b0);
    send_beat(8'($urandom), 1'b1);

    // Random part: mostly text and well-formed sequences, some breakage and noise.
    round = 0;
    while (beats_sent < directed_q.size() + 1 + RandomBeats) begin
      if (round % 30 == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet <= ($urandom_range(0, 3) == 0);
      end
      round++;
      kind = $urandom_range(0, 99);
      if (kind < 33) begin
        send_beat(8'($urandom_range(32'h20, 32'h7F)), 1'b0);
      end else if (kind < 48) begin
        case ($urandom_range(0, 5))
          0: send_beat(ChQuote, 1'b0);
          1: send_beat(ChBackslash, 1'b0);
          2: send_beat(ChNewline, 1'b0);
          3: send_beat(ChReturn, 1'b0);
          4: send_beat(ChTab, 1'b0);
          default: send_beat(8'($urandom_range(0, 31)), 1'b0);
        endcase
      end else if (kind < 72) begin
        send_utf8($urandom_range(2, 4), 0);
      end else if (kind < 82) begin
        // Broken sequence, followed by text, a new sequence or an end mark.
        len = $urandom_range(2, 4);
        send_utf8(len, $urandom_range(1, len - 1));
        case ($urandom_range(0, 2))
          0: send_beat(8'($urandom_range(0, 127)), 1'b0);
          1: send_utf8($urandom_range(2, 4), 0);
          default: send_beat(8'($urandom), 1'b1);
        endcase
      end else if (kind < 88) begin
        if ($urandom_range(0, 1) == 0) send_beat(ContBase + 8'($urandom_range(0, 63)), 1'b0);
        else send_beat(InvalidLead + 8'($urandom_range(0, 7)), 1'b0);
      end else if (kind < 93) begin
        send_beat(8'($urandom), 1'b1);
      end else begin
        send_beat(8'($urandom), 1'b0);
      end
    end
    in_valid <= 1'b0;

    // Drain the expected bytes, then watch a little longer for extra output.
    @(posedge clk);
    while (bytes_owed != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0 && bytes_owed == 0) begin
      $display("** json_string_escaper_utf8_filter: PASSED **");
    end else begin
      $display("** json_string_escaper_utf8_filter: FAILED **");
    end
    $finish;
  end

endmodule
